// ----- rtl/rotpt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rotpt_pkg;

   // Angle field and table geometry.
   localparam int ANGLE_W   = 11;
   localparam int ANGLE_MAX = 629;
   localparam int IDX_W     = 10;

   // Fraction bits of the high-precision values used to build the tables.
   localparam int QB = 61;

   localparam int TRIG_ENTRY_W = 32;

   typedef logic signed [TRIG_ENTRY_W-1:0] trig_table_type [0:ANGLE_MAX];

   // (a * b + 2^(QB-1)) >> QB, kept to 64 bits.
   function automatic logic [63:0] umulq(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      p = p + (128'd1 << (QB - 1));
      return p[QB+63:QB];
   endfunction

   function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
      logic        neg;
      logic [63:0] ma;
      logic [63:0] mb;
      logic [63:0] m;
      neg = a[63] ^ b[63];
      ma  = a[63] ? 64'(-a) : 64'(a);
      mb  = b[63] ? 64'(-b) : 64'(b);
      m   = umulq(ma, mb);
      return neg ? $signed(64'(-m)) : $signed(m);
   endfunction

   // Rounds a high-precision value to frac_bits fraction bits, halves away from zero.
   function automatic logic signed [63:0] to_rom(input logic signed [63:0] v,
                                                 input int frac_bits);
      int          sh;
      logic        neg;
      logic [63:0] m;
      sh  = QB - frac_bits;
      neg = v[63];
      m   = neg ? 64'(-v) : 64'(v);
      m   = (m + (64'd1 << (sh - 1))) >> sh;
      return neg ? $signed(64'(-m)) : $signed(m);
   endfunction

   // Builds the cosine (want_sin = 0) or sine table for angles 0.00 to 6.29 rad.
   // A Taylor series gives cos and sin of one step, and an angle-addition
   // recurrence walks the table.
   function automatic trig_table_type build_trig_table(input int frac_bits,
                                                       input bit want_sin);
      trig_table_type    tbl;
      logic [63:0]       x;
      logic [63:0]       term;
      logic signed [63:0] c1;
      logic signed [63:0] s1;
      logic signed [63:0] c;
      logic signed [63:0] s;
      logic signed [63:0] nc;
      logic signed [63:0] ns;
      logic signed [63:0] t;
      logic signed [63:0] r;
      x    = ((64'd1 << QB) + 64'd50) / 64'd100;
      term = 64'd1 << QB;
      c1   = $signed(64'd1 << QB);
      s1   = '0;
      c    = $signed(64'd1 << QB);
      s    = '0;
      for (int n = 1; n <= 12; n++) begin
         term = (umulq(term, x) + 64'(n / 2)) / 64'(n);
         t = (((n / 2) % 2) != 0) ? $signed(64'(-term)) : $signed(term);
         if ((n % 2) != 0) begin
            s1 = s1 + t;
         end else begin
            c1 = c1 + t;
         end
      end
      for (int k = 0; k <= ANGLE_MAX; k++) begin
         r = want_sin ? to_rom(s, frac_bits) : to_rom(c, frac_bits);
         tbl[k] = r[TRIG_ENTRY_W-1:0];
         nc = qmul(c, c1) - qmul(s, s1);
         ns = qmul(s, c1) + qmul(c, s1);
         c = nc;
         s = ns;
      end
      return tbl;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/rotate_point_about_center_core.sv -----
// Rotates a point about a center by a signed angle, one point per transaction.
// Input channel (req_): point and center coordinates in hundredths of a unit
// and the angle in hundredths of a radian. Magnitudes above 6.29 rad are
// clamped to 6.29 with the sign kept. Result channel (rsp_): the rotated
// point, truncated toward zero, two bits wider than the coordinates.
// Each accepted transaction passes through the input stage, the cos/sin table
// read, the multiply, the sum and the output register before it shows on
// rsp_valid. Throughput is one transaction per cycle while the skid register
// is empty; the five-stage pipeline with its single table read per item sets it.
// When the receiver stalls, a completed result moves into a one-entry skid
// register; req_ready comes from that skid register alone, so the whole
// pipeline holds in place while it is full and nothing is dropped or
// repeated. Synchronous reset empties all stages; the cos/sin tables are
// constant and need no initialization.
`timescale 1ns / 1ps
`default_nettype none

module rotate_point_about_center_core #(
   parameter int COORD_BITS     = 24,
   parameter int TRIG_FRAC_BITS = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic signed [COORD_BITS-1:0]         req_point_x,
   input  wire logic signed [COORD_BITS-1:0]         req_point_y,
   input  wire logic signed [COORD_BITS-1:0]         req_center_x,
   input  wire logic signed [COORD_BITS-1:0]         req_center_y,
   input  wire logic signed [rotpt_pkg::ANGLE_W-1:0] req_angle,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed [COORD_BITS+1:0]              rsp_rotated_x,
   output logic signed [COORD_BITS+1:0]              rsp_rotated_y
);
   import rotpt_pkg::*;

   localparam int C      = COORD_BITS;
   localparam int F      = TRIG_FRAC_BITS;
   localparam int D      = C + 1;
   localparam int TW     = F + 2;
   localparam int P      = TW + D;
   localparam int O      = C + 2;
   localparam int FULL_W = F + D + 3;
   localparam int ACC_W  = (FULL_W > 64) ? 64 : FULL_W;

   logic advance;
   logic accept;

   // Stage 1: angle magnitude and coordinate differences.
   logic                  v1_ff;
   logic [IDX_W-1:0]      mag_ff;
   logic [IDX_W-1:0]      mag_in;
   logic [ANGLE_W-1:0]    abs_angle;
   logic                  neg1_ff;
   logic signed [D-1:0]   dx1_ff, dy1_ff, dx1_in, dy1_in;
   logic signed [C-1:0]   cx1_ff, cy1_ff;

   // Stage 2: table read, differences steered for the sine sign.
   logic                  v2_ff;
   logic signed [TW-1:0]  cos2, sin2;
   logic signed [D-1:0]   dx2_ff, dy2_ff, sdx2_ff, sdy2_ff;
   logic signed [C-1:0]   cx2_ff, cy2_ff;

   // Stage 3: products.
   logic                  v3_ff;
   logic signed [P-1:0]   pcx3_ff, psx3_ff, pcy3_ff, psy3_ff;
   logic signed [C-1:0]   cx3_ff, cy3_ff;

   // Stage 4: sums.
   logic                  v4_ff;
   logic signed [FULL_W-1:0] sum_x_in, sum_y_in;
   logic signed [ACC_W-1:0]  acc_x_ff, acc_y_ff;

   // Output and skid registers.
   logic                  out_vld_ff, skid_vld_ff;
   logic signed [O-1:0]   out_x_ff, out_y_ff, skid_x_ff, skid_y_ff;
   logic signed [O-1:0]   fin_x, fin_y;
   logic signed [ACC_W-1:0] bias_x, bias_y, shx, shy;
   logic                  pop;
   logic                  incoming;

   assign advance   = !skid_vld_ff;
   assign req_ready = advance;
   assign accept    = req_valid && advance;

   assign abs_angle = req_angle[ANGLE_W-1] ? ANGLE_W'(-req_angle) : ANGLE_W'(req_angle);
   assign mag_in    = (abs_angle > ANGLE_W'(ANGLE_MAX)) ? IDX_W'(ANGLE_MAX)
                                                        : abs_angle[IDX_W-1:0];
   assign dx1_in = {req_point_x[C-1], req_point_x} - {req_center_x[C-1], req_center_x};
   assign dy1_in = {req_point_y[C-1], req_point_y} - {req_center_y[C-1], req_center_y};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mag_ff  <= mag_in;
         neg1_ff <= req_angle[ANGLE_W-1];
         dx1_ff  <= dx1_in;
         dy1_ff  <= dy1_in;
         cx1_ff  <= req_center_x;
         cy1_ff  <= req_center_y;
      end
   end

   rotpt_trig_rom #(
      .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
   ) u_trig_rom (
      .clock    (clock),
      .en       (advance),
      .idx      (mag_ff),
      .cos_value(cos2),
      .sin_value(sin2)
   );

   // A negative angle negates sine; that sign is folded into the
   // differences that sine multiplies.
   always_ff @(posedge clock) begin
      if (advance) begin
         dx2_ff  <= dx1_ff;
         dy2_ff  <= dy1_ff;
         sdy2_ff <= neg1_ff ? D'(-dy1_ff) : dy1_ff;
         sdx2_ff <= neg1_ff ? dx1_ff : D'(-dx1_ff);
         cx2_ff  <= cx1_ff;
         cy2_ff  <= cy1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pcx3_ff <= P'(cos2) * P'(dx2_ff);
         psx3_ff <= P'(sin2) * P'(sdy2_ff);
         pcy3_ff <= P'(cos2) * P'(dy2_ff);
         psy3_ff <= P'(sin2) * P'(sdx2_ff);
         cx3_ff  <= cx2_ff;
         cy3_ff  <= cy2_ff;
      end
   end

   assign sum_x_in = {{(FULL_W-P){pcx3_ff[P-1]}}, pcx3_ff}
                   + {{(FULL_W-P){psx3_ff[P-1]}}, psx3_ff}
                   + ({{(FULL_W-C){cx3_ff[C-1]}}, cx3_ff} <<< F);
   assign sum_y_in = {{(FULL_W-P){pcy3_ff[P-1]}}, pcy3_ff}
                   + {{(FULL_W-P){psy3_ff[P-1]}}, psy3_ff}
                   + ({{(FULL_W-C){cy3_ff[C-1]}}, cy3_ff} <<< F);

   always_ff @(posedge clock) begin
      if (advance) begin
         acc_x_ff <= sum_x_in[ACC_W-1:0];
         acc_y_ff <= sum_y_in[ACC_W-1:0];
      end
   end

   // Adding 2^F - 1 to a negative sum before the arithmetic shift
   // turns the floor into truncation toward zero.
   assign bias_x = acc_x_ff + (acc_x_ff[ACC_W-1] ? ACC_W'((64'd1 << F) - 64'd1) : '0);
   assign bias_y = acc_y_ff + (acc_y_ff[ACC_W-1] ? ACC_W'((64'd1 << F) - 64'd1) : '0);
   assign shx    = bias_x >>> F;
   assign shy    = bias_y >>> F;
   assign fin_x  = shx[O-1:0];
   assign fin_y  = shy[O-1:0];

   assign pop      = out_vld_ff && rsp_ready;
   assign incoming = advance && v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (pop || !out_vld_ff) begin
         out_vld_ff  <= skid_vld_ff || incoming;
         skid_vld_ff <= 1'b0;
      end else if (incoming) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop || !out_vld_ff) begin
         if (skid_vld_ff) begin
            out_x_ff <= skid_x_ff;
            out_y_ff <= skid_y_ff;
         end else begin
            out_x_ff <= fin_x;
            out_y_ff <= fin_y;
         end
      end else if (incoming) begin
         skid_x_ff <= fin_x;
         skid_y_ff <= fin_y;
      end
   end

   assign rsp_valid     = out_vld_ff;
   assign rsp_rotated_x = out_x_ff;
   assign rsp_rotated_y = out_y_ff;

endmodule

`default_nettype wire

// ----- rtl/rotpt_trig_rom.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rotpt_trig_rom #(
   parameter int TRIG_FRAC_BITS = 16
) (
   input  wire logic                            clock,
   input  wire logic                            en,
   input  wire logic [rotpt_pkg::IDX_W-1:0]     idx,
   output logic signed [TRIG_FRAC_BITS+1:0]     cos_value,
   output logic signed [TRIG_FRAC_BITS+1:0]     sin_value
);
   import rotpt_pkg::*;

   localparam int TW = TRIG_FRAC_BITS + 2;

   localparam trig_table_type COS_ROM = build_trig_table(TRIG_FRAC_BITS, 1'b0);
   localparam trig_table_type SIN_ROM = build_trig_table(TRIG_FRAC_BITS, 1'b1);

   logic signed [TW-1:0] cos_ff;
   logic signed [TW-1:0] sin_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= COS_ROM[idx][TW-1:0];
         sin_ff <= SIN_ROM[idx][TW-1:0];
      end
   end

   assign cos_value = cos_ff;
   assign sin_value = sin_ff;

endmodule

`default_nettype wire
